>>> hdl/sor_pkg.sv
// Shared constants and types for the spiral order matrix reader.
`default_nettype none
package sor_pkg;
   localparam int MAX_ROWS   = 16;
   localparam int MAX_COLS   = 16;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int DEPTH      = MAX_ROWS * MAX_COLS;
   localparam int DATA_W     = 32;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COUNT    = 2'd0,
      CSR_COLUMN_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      PH_TOP    = 2'd0,
      PH_RIGHT  = 2'd1,
      PH_BOTTOM = 2'd2,
      PH_LEFT   = 2'd3
   } phase_type;
endpackage
`default_nettype wire

>>> hdl/sor_if.sv
// Valid/ready channel interfaces: request, response and register write.
`default_nettype none
interface sor_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [3:0]         write_row;
   logic [3:0]         write_column;
   logic signed [31:0] write_value;
   modport source (output valid, cmd, write_row, write_column, write_value, input ready);
   modport sink   (input valid, cmd, write_row, write_column, write_value, output ready);
endinterface

interface sor_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] element_value;
   logic [3:0]         element_row;
   logic [3:0]         element_column;
   logic               scan_last;
   modport source (output valid, element_value, element_row, element_column, scan_last,
                   input ready);
   modport sink   (input valid, element_value, element_row, element_column, scan_last,
                   output ready);
endinterface

interface sor_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [4:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/spiral_order_matrix_reader_top.sv
// Spiral order matrix reader: element store plus clockwise spiral cursor.
//
// A write request stores one signed 32-bit word at (write_row, write_column) and
// gives no response. A read request returns the element at the current spiral
// position with its row, column and a last flag, then moves the cursor; after
// the last element the scan restarts at the outer ring. One request is taken
// per cycle while the response side keeps up; a read passes through the store
// read register and then the output register, which loads only when it is
// empty or its response is taken. When the output register is held, at most
// one read waits in the store read stage and further requests stall. Writing
// either count register restarts the scan; reading an element never written
// returns an undefined value. The store needs no clearing after reset.
`default_nettype none
module spiral_order_matrix_reader_top (
   input  wire logic  clock,
   input  wire logic  reset,
   sor_req_if.sink    req_ch,
   sor_rsp_if.source  rsp_ch,
   sor_csr_if.sink    csr_ch
);
   import sor_pkg::*;

   logic signed [DATA_W-1:0] matrix_mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   logic [COUNT_W-1:0] row_count_ff, row_count_in;
   logic [COUNT_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0]   ring_ff, ring_in;
   phase_type          phase_ff, phase_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;

   logic               pend_ff, pend_in;
   logic [ROW_W-1:0]   pend_row_ff;
   logic [COL_W-1:0]   pend_col_ff;
   logic               pend_last_ff;

   logic               out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_value_ff;
   logic [ROW_W-1:0]   out_row_ff;
   logic [COL_W-1:0]   out_col_ff;
   logic               out_last_ff;

   logic               req_fire, rd_fire, wr_fire, csr_fire, csr_hit, move;
   logic [COUNT_W-1:0] rows_eff, cols_eff, s5, ex5, ey5, crow5, ccol5;
   logic [COUNT_W:0]   ring_nx6, two_r6;
   logic               ring_more, wrap;

   // effective counts: zero acts as one, saturate at the store size
   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = COUNT_W'(1);
      end else if (row_count_ff > COUNT_W'(MAX_ROWS)) begin
         rows_eff = COUNT_W'(MAX_ROWS);
      end else begin
         rows_eff = row_count_ff;
      end
      if (column_count_ff == '0) begin
         cols_eff = COUNT_W'(1);
      end else if (column_count_ff > COUNT_W'(MAX_COLS)) begin
         cols_eff = COUNT_W'(MAX_COLS);
      end else begin
         cols_eff = column_count_ff;
      end
   end

   assign move     = pend_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !pend_ff || move;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rd_fire  = req_fire && (req_ch.cmd == CMD_READ);
   assign wr_fire  = req_fire && (req_ch.cmd == CMD_WRITE);
   assign csr_ch.ready = 1'b1;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign csr_hit  = csr_fire && ((csr_ch.index == CSR_ROW_COUNT) ||
                                  (csr_ch.index == CSR_COLUMN_COUNT));

   assign s5     = COUNT_W'(ring_ff);
   assign ex5    = cols_eff - COUNT_W'(1) - s5;
   assign ey5    = rows_eff - COUNT_W'(1) - s5;
   assign crow5  = COUNT_W'(cur_row_ff);
   assign ccol5  = COUNT_W'(cur_col_ff);
   assign ring_nx6 = (COUNT_W+1)'(ring_ff) + (COUNT_W+1)'(1);
   assign two_r6 = ring_nx6 << 1;
   assign ring_more = ((COUNT_W+1)'(cols_eff) > two_r6) &&
                      ((COUNT_W+1)'(rows_eff) > two_r6);

   // spiral cursor: next position and wrap
   always_comb begin
      logic to_next_ring;
      to_next_ring = 1'b0;
      ring_in    = ring_ff;
      phase_in   = phase_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      case (phase_ff)
         PH_TOP: begin
            if (ccol5 < ex5) begin
               cur_col_in = cur_col_ff + COL_W'(1);
            end else if (s5 < ey5) begin
               phase_in   = PH_RIGHT;
               cur_row_in = ring_ff + ROW_W'(1);
               cur_col_in = COL_W'(ex5);
            end else begin
               to_next_ring = 1'b1;
            end
         end
         PH_RIGHT: begin
            if (crow5 < ey5) begin
               cur_row_in = cur_row_ff + ROW_W'(1);
            end else if (s5 < ex5) begin
               phase_in   = PH_BOTTOM;
               cur_row_in = ROW_W'(ey5);
               cur_col_in = COL_W'(ex5 - COUNT_W'(1));
            end else begin
               to_next_ring = 1'b1;
            end
         end
         PH_BOTTOM: begin
            if (ccol5 > s5) begin
               cur_col_in = cur_col_ff - COL_W'(1);
            end else if ((s5 + COUNT_W'(1)) < ey5) begin
               phase_in   = PH_LEFT;
               cur_row_in = ROW_W'(ey5 - COUNT_W'(1));
               cur_col_in = COL_W'(ring_ff);
            end else begin
               to_next_ring = 1'b1;
            end
         end
         PH_LEFT: begin
            if (crow5 > (s5 + COUNT_W'(1))) begin
               cur_row_in = cur_row_ff - ROW_W'(1);
            end else begin
               to_next_ring = 1'b1;
            end
         end
         default: begin
            to_next_ring = 1'b1;
         end
      endcase
      wrap = to_next_ring && !ring_more;
      if (to_next_ring) begin
         if (ring_more) begin
            ring_in    = ROW_W'(ring_nx6);
            cur_row_in = ROW_W'(ring_nx6);
            cur_col_in = COL_W'(ring_nx6);
         end else begin
            ring_in    = '0;
            cur_row_in = '0;
            cur_col_in = '0;
         end
         phase_in = PH_TOP;
      end
      if (!rd_fire) begin
         ring_in    = ring_ff;
         phase_in   = phase_ff;
         cur_row_in = cur_row_ff;
         cur_col_in = cur_col_ff;
      end
      if (csr_hit) begin
         ring_in    = '0;
         phase_in   = PH_TOP;
         cur_row_in = '0;
         cur_col_in = '0;
      end
   end

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_fire && (csr_ch.index == CSR_ROW_COUNT)) begin
         row_count_in = csr_ch.data;
      end
      if (csr_fire && (csr_ch.index == CSR_COLUMN_COUNT)) begin
         column_count_in = csr_ch.data;
      end
      pend_in      = rd_fire || (pend_ff && !move);
      out_valid_in = move || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= COUNT_W'(4);
         column_count_ff <= COUNT_W'(4);
         ring_ff         <= '0;
         phase_ff        <= PH_TOP;
         cur_row_ff      <= '0;
         cur_col_ff      <= '0;
         pend_ff         <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         ring_ff         <= ring_in;
         phase_ff        <= phase_in;
         cur_row_ff      <= cur_row_in;
         cur_col_ff      <= cur_col_in;
         pend_ff         <= pend_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // element store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         matrix_mem[{req_ch.write_row, req_ch.write_column}] <= req_ch.write_value;
      end
      if (rd_fire) begin
         rd_data_ff <= matrix_mem[{cur_row_ff, cur_col_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_fire) begin
         pend_row_ff  <= cur_row_ff;
         pend_col_ff  <= cur_col_ff;
         pend_last_ff <= wrap;
      end
      if (move) begin
         out_value_ff <= rd_data_ff;
         out_row_ff   <= pend_row_ff;
         out_col_ff   <= pend_col_ff;
         out_last_ff  <= pend_last_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.element_value  = out_value_ff;
   assign rsp_ch.element_row    = out_row_ff;
   assign rsp_ch.element_column = out_col_ff;
   assign rsp_ch.scan_last      = out_last_ff;

   a_cursor_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (crow5 < rows_eff) && (ccol5 < cols_eff))
      else $error("spiral cursor outside matrix");

   a_ring_in_bounds: assert property (@(posedge clock) disable iff (reset)
      ({s5, 1'b0} < (COUNT_W+1)'(rows_eff)) && ({s5, 1'b0} < (COUNT_W+1)'(cols_eff)))
      else $error("ring index beyond matrix");

   a_read_pends: assert property (@(posedge clock) disable iff (reset)
      rd_fire |=> pend_ff)
      else $error("read transfer lost before store read");

   a_pend_held: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && out_valid_ff && !rsp_ch.ready) |=> (pend_ff && out_valid_ff))
      else $error("pending read dropped while output stalled");

   a_wrap_restarts: assert property (@(posedge clock) disable iff (reset)
      (rd_fire && wrap && !csr_hit) |=> (ring_ff == '0 && phase_ff == PH_TOP &&
                                         cur_row_ff == '0 && cur_col_ff == '0))
      else $error("scan did not restart after last element");
endmodule
`default_nettype wire

>>> verif/tb_spiral_order_matrix_reader_top.sv
// Self-checking testbench for the spiral order matrix reader: random traffic, spiral predictor.
module tb_spiral_order_matrix_reader_top;
   import sor_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      cmd_type                   cmd;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          column;
      logic signed [DATA_W-1:0]  value;
   } request_type;

   typedef struct {
      logic signed [DATA_W-1:0]  value;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          column;
      logic                      last;
   } element_type;

   logic clock;
   logic reset;

   sor_req_if req_ch();
   sor_rsp_if rsp_ch();
   sor_csr_if csr_ch();

   spiral_order_matrix_reader_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   request_type request_queue[$];
   element_type expected_elements[$];
   int       send_idle_pct;
   int       recv_idle_pct;
   bit       hold_request;
   int       hold_left;
   int       mismatch_count;
   int       idle_cycles;

   // predictor copy of the block
   logic signed [DATA_W-1:0] shadow_mem [DEPTH];
   logic [COUNT_W-1:0]       row_cfg;
   logic [COUNT_W-1:0]       col_cfg;
   int                       spiral_ring;
   phase_type                spiral_side;
   int                       cur_row;
   int                       cur_col;

   // stimulus bookkeeping: which cells hold data, size of the region in use
   bit gen_written [DEPTH];
   int gen_rows;
   int gen_cols;

   function automatic int clamp_count(logic [COUNT_W-1:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void restart_spiral();
      spiral_ring = 0;
      spiral_side = PH_TOP;
      cur_row     = 0;
      cur_col     = 0;
   endfunction

   function automatic bit enter_next_ring(int rows, int cols);
      int r;
      r = spiral_ring + 1;
      if (cols > 2 * r && rows > 2 * r) begin
         spiral_ring = r;
         spiral_side = PH_TOP;
         cur_row     = r;
         cur_col     = r;
         return 1'b0;
      end
      restart_spiral();
      return 1'b1;
   endfunction

   // moves the cursor one position; returns 1 when the scan wraps
   function automatic bit advance_spiral(int rows, int cols);
      int s;
      int ex;
      int ey;
      s  = spiral_ring;
      ex = cols - 1 - s;
      ey = rows - 1 - s;
      case (spiral_side)
         PH_TOP: begin
            if (cur_col < ex) cur_col++;
            else if (s < ey) begin
               spiral_side = PH_RIGHT;
               cur_row     = s + 1;
               cur_col     = ex;
            end else return enter_next_ring(rows, cols);
         end
         PH_RIGHT: begin
            if (cur_row < ey) cur_row++;
            else if (s < ex) begin
               spiral_side = PH_BOTTOM;
               cur_row     = ey;
               cur_col     = ex - 1;
            end else return enter_next_ring(rows, cols);
         end
         PH_BOTTOM: begin
            if (cur_col > s) cur_col--;
            else if (s + 1 < ey) begin
               spiral_side = PH_LEFT;
               cur_row     = ey - 1;
               cur_col     = s;
            end else return enter_next_ring(rows, cols);
         end
         default: begin
            if (cur_row > s + 1) cur_row--;
            else return enter_next_ring(rows, cols);
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void predict_request(request_type rq);
      element_type el;
      if (rq.cmd == CMD_WRITE) begin
         shadow_mem[rq.row * MAX_COLS + rq.column] = rq.value;
         return;
      end
      el.value  = shadow_mem[cur_row * MAX_COLS + cur_col];
      el.row    = cur_row[ROW_W-1:0];
      el.column = cur_col[COL_W-1:0];
      el.last   = advance_spiral(clamp_count(row_cfg, MAX_ROWS), clamp_count(col_cfg, MAX_COLS));
      expected_elements.push_back(el);
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
      if (idx == CSR_ROW_COUNT) row_cfg = val;
      else if (idx == CSR_COLUMN_COUNT) col_cfg = val;
      else return;
      restart_spiral();
   endfunction

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic void queue_write(int r, int c, logic signed [DATA_W-1:0] v);
      request_type rq;
      rq.cmd    = CMD_WRITE;
      rq.row    = r[ROW_W-1:0];
      rq.column = c[COL_W-1:0];
      rq.value  = v;
      request_queue.push_back(rq);
      gen_written[r * MAX_COLS + c] = 1'b1;
   endfunction

   function automatic void queue_read();
      request_type rq;
      rq.cmd    = CMD_READ;
      rq.row    = ROW_W'($urandom_range(MAX_ROWS - 1));
      rq.column = COL_W'($urandom_range(MAX_COLS - 1));
      rq.value  = $urandom;
      request_queue.push_back(rq);
   endfunction

   // every cell the scan can reach must hold data before any read
   function automatic void fill_region();
      for (int r = 0; r < gen_rows; r++)
         for (int c = 0; c < gen_cols; c++)
            if (!gen_written[r * MAX_COLS + c]) queue_write(r, c, random_value());
   endfunction

   function automatic void queue_mix(int n, int read_pct);
      int r;
      int c;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < read_pct) queue_read();
         else begin
            if ($urandom_range(1) == 0) begin
               r = $urandom_range(gen_rows - 1);
               c = $urandom_range(gen_cols - 1);
            end else begin
               r = $urandom_range(MAX_ROWS - 1);
               c = $urandom_range(MAX_COLS - 1);
            end
            queue_write(r, c, random_value());
         end
      end
   endfunction

   // checked at the falling edge, once the driver has settled for the cycle
   task automatic wait_idle();
      do @(negedge clock);
      while (request_queue.size() != 0 || req_ch.valid || expected_elements.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      apply_csr(idx, val);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int rv, int cv);
      wait_idle();
      csr_write(CSR_ROW_COUNT, rv[COUNT_W-1:0]);
      csr_write(CSR_COLUMN_COUNT, cv[COUNT_W-1:0]);
      gen_rows = clamp_count(rv[COUNT_W-1:0], MAX_ROWS);
      gen_cols = clamp_count(cv[COUNT_W-1:0], MAX_COLS);
      fill_region();
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin : request_driver
      request_type rq;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            rq.cmd    = cmd_type'(req_ch.cmd);
            rq.row    = req_ch.write_row;
            rq.column = req_ch.write_column;
            rq.value  = req_ch.write_value;
            predict_request(rq);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               rq = request_queue.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.cmd          <= rq.cmd;
               req_ch.write_row    <= rq.row;
               req_ch.write_column <= rq.column;
               req_ch.write_value  <= rq.value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : element_monitor
      element_type want;
      element_type got;
      logic        take;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.value  = rsp_ch.element_value;
            got.row    = rsp_ch.element_row;
            got.column = rsp_ch.element_column;
            got.last   = rsp_ch.scan_last;
            if (expected_elements.size() == 0) begin
               $display("%0t: unexpected transfer value=%0d row=%0d col=%0d last=%0b",
                        $time, got.value, got.row, got.column, got.last);
               mismatch_count++;
            end else begin
               want = expected_elements.pop_front();
               if (got.value !== want.value || got.row !== want.row ||
                   got.column !== want.column || got.last !== want.last) begin
                  $display("%0t: expected %0d r%0d c%0d l%0b, got %0d r%0d c%0d l%0b",
                           $time, want.value, want.row, want.column, want.last,
                           got.value, got.row, got.column, got.last);
                  mismatch_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            take         = 1'b0;
         end else begin
            take = ($urandom_range(99) >= recv_idle_pct);
         end
         rsp_ch.ready <= take;
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int rv;
      int cv;
      int n;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_WRITE;
      req_ch.write_row    = '0;
      req_ch.write_column = '0;
      req_ch.write_value  = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_ROW_COUNT;
      csr_ch.data         = '0;
      mismatch_count      = 0;
      idle_cycles         = 0;
      hold_request        = 1'b0;
      hold_left           = 0;
      send_idle_pct       = 0;
      recv_idle_pct       = 0;
      row_cfg             = 5'd4;
      col_cfg             = 5'd4;
      restart_spiral();
      gen_rows            = 4;
      gen_cols            = 4;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // 2x3 matrix holding the value extremes, plus the far corner of the store
      @(posedge clock);
      csr_write(CSR_ROW_COUNT, 5'd2);
      csr_write(CSR_COLUMN_COUNT, 5'd3);
      gen_rows = 2;
      gen_cols = 3;
      queue_write(0, 0, 32'h8000_0000);
      queue_write(0, 1, 32'h7fff_ffff);
      queue_write(0, 2, 32'h0000_0000);
      queue_write(1, 2, 32'hffff_ffff);
      queue_write(1, 1, 32'h0000_0001);
      queue_write(1, 0, 32'h5a5a_a5a5);
      queue_write(MAX_ROWS - 1, MAX_COLS - 1, 32'ha5a5_5a5a);
      repeat (3) queue_read();
      // writes to unmapped indexes must not restart the scan
      wait_idle();
      csr_write(CSR_SPARE_2, 5'd31);
      csr_write(CSR_SPARE_3, 5'd0);
      repeat (5) queue_read();

      for (int seg = 0; seg < 3; seg++) begin
         case (seg)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int k = 0; k < 6; k++) begin
            case (seg * 6 + k)
               0: begin rv = 0;  cv = 0;  end
               1: begin rv = 31; cv = 31; end
               2: begin rv = 1;  cv = 16; end
               3: begin rv = 16; cv = 1;  end
               4: begin rv = 17; cv = 2;  end
               5: begin rv = 2;  cv = 17; end
               6: begin rv = 16; cv = 16; end
               7: begin rv = 3;  cv = 3;  end
               8: begin rv = 2;  cv = 2;  end
               9: begin rv = 3;  cv = 5;  end
               10: begin rv = 5; cv = 3;  end
               default: begin
                  rv = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 6);
                  cv = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 6);
               end
            endcase
            configure(rv, cv);
            n = 20 + gen_rows * gen_cols;
            queue_mix(n, 70);
            // long response stall while requests keep coming
            if (seg == 2 && k == 2) hold_request = 1'b1;
         end
      end

      wait_idle();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
